// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the detector.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  `ASSERT_PROP(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  `ASSERT_PROP(lbl, (ante) |=> (cons), msg)

`endif

// ----- hw/rtl/wcd_pkg.sv -----
// Package for the windowed convergence detector: widths, codes, payload types,
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package wcd_pkg;

  localparam int WINDOW_MAX = 16;

  localparam int SAMPLE_W   = 48;
  localparam int TOL_W      = 47;
  localparam int ITER_W     = 24;
  localparam int WS_W       = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 47;

  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int PTR_W  = $clog2(WINDOW_MAX);
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int REV_W  = CNT_W + 4;

  localparam logic [ITER_W-1:0] ITER_MAX = '1;

  localparam logic [TOL_W-1:0]  TOL_RESET     = TOL_W'(66);
  localparam logic [ITER_W-1:0] MAX_ITER_RESET = ITER_W'(1000);
  localparam logic [WS_W-1:0]   WS_RESET      = WS_W'(5);

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    TREND_EMPTY       = 2'd0,
    TREND_CONVERGING  = 2'd1,
    TREND_OSCILLATING = 2'd2,
    TREND_STAGNATING  = 2'd3
  } trend_t;

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample;
  } wcd_in_t;

  typedef struct packed {
    logic              converged;
    logic              limit_reached;
    trend_t            trend;
    logic [ITER_W-1:0] iteration_count;
  } wcd_out_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic read_en;
    logic eval_load;
  } wcd_cmd_t;

  typedef struct packed {
    logic empty;
    logic read_last;
    logic out_busy;
  } wcd_stat_t;

  // Clamp the window size register to [1, WINDOW_MAX].
  function automatic logic [CNT_W-1:0] eff_window(input logic [WS_W-1:0] ws);
    logic [CNT_W-1:0] r;
    if (ws == '0) begin
      r = CNT_W'(1);
    end else if (int'(ws) > WINDOW_MAX) begin
      r = CNT_W'(WINDOW_MAX);
    end else begin
      r = CNT_W'(ws);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/windowed_convergence_detector.sv -----
// Top level of the windowed convergence detector: controller plus datapath.
// Depends on wcd_pkg, wcd_ctrl and wcd_datapath.
//
//   channel   signals                                  beat
//   item      item_valid / item_ready / item           cmd + sample
//   result    result_valid / result_ready / result     flags, trend, count
//   config    cfg_we / cfg_index / cfg_data            one register write
//
// An add walks the window memory from newest to oldest entry, one read per
// cycle, over n entries, n being the window fill after the add (at most 16);
// a clear skips the walk. A new item is accepted only once the previous one
// has been evaluated. Synchronous reset empties the window, zeroes the count
// and loads register defaults. A waiting result holds in its register while
// the next item is accepted; evaluation stalls only if that register is
// still full.
`default_nettype none

module windowed_convergence_detector (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_ready,
  input  wire wcd_pkg::wcd_in_t               item,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output wcd_pkg::wcd_out_t                   result,
  input  wire logic                           cfg_we,
  input  wire logic [wcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wcd_pkg::CFG_DATA_W-1:0] cfg_data
);

  wcd_pkg::wcd_cmd_t  cmd;
  wcd_pkg::wcd_stat_t stat;

  wcd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  wcd_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/wcd_ctrl.sv -----
// Controller of the windowed convergence detector: accept, set up, walk the
// window memory, evaluate. Uses wcd_pkg command and status structs.
`default_nettype none

module wcd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire wcd_pkg::wcd_stat_t stat,
  output wcd_pkg::wcd_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_READ  = 5'b00100,
    S_WAIT  = 5'b01000,
    S_EVAL  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_SETUP;
      end
      S_SETUP: begin
        state_next = stat.empty ? S_EVAL : S_READ;
      end
      S_READ: begin
        if (stat.read_last) state_next = S_WAIT;
      end
      S_WAIT: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        // hold until the result register is free
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign item_ready    = (state == S_IDLE);
  assign cmd.accept    = (state == S_IDLE) && item_valid;
  assign cmd.setup     = (state == S_SETUP);
  assign cmd.read_en   = (state == S_READ);
  assign cmd.eval_load = (state == S_EVAL) && !stat.out_busy;

endmodule

`default_nettype wire

// ----- hw/rtl/wcd_datapath.sv -----
// Datapath of the windowed convergence detector: configuration registers,
// circular window memory, scan accumulators and result register. Uses wcd_pkg.
`default_nettype none

module wcd_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire wcd_pkg::wcd_in_t                  item,
  input  wire logic                              cfg_we,
  input  wire logic [wcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wcd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire wcd_pkg::wcd_cmd_t                 cmd,
  output wcd_pkg::wcd_stat_t                     stat,
  input  wire logic                              result_ready,
  output logic                                   result_valid,
  output wcd_pkg::wcd_out_t                      result
);

  // configuration
  logic [wcd_pkg::TOL_W-1:0]  tolerance;
  logic [wcd_pkg::ITER_W-1:0] max_iterations;
  logic [wcd_pkg::WS_W-1:0]   window_size;
  logic [wcd_pkg::CNT_W-1:0]  ws;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= wcd_pkg::TOL_RESET;
      max_iterations <= wcd_pkg::MAX_ITER_RESET;
      window_size    <= wcd_pkg::WS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == wcd_pkg::CFG_TOLERANCE) begin
        tolerance <= cfg_data[wcd_pkg::TOL_W-1:0];
      end
      if (cfg_index == wcd_pkg::CFG_MAX_ITER) begin
        max_iterations <= cfg_data[wcd_pkg::ITER_W-1:0];
      end
      if (cfg_index == wcd_pkg::CFG_WINDOW_SIZE) begin
        window_size <= cfg_data[wcd_pkg::WS_W-1:0];
      end
    end
  end

  assign ws = wcd_pkg::eff_window(window_size);

  // window state: head points at the newest entry
  logic [wcd_pkg::SAMPLE_W-1:0] window_mem [wcd_pkg::WINDOW_MAX];
  logic [wcd_pkg::PTR_W-1:0]    head, head_inc;
  logic [wcd_pkg::CNT_W-1:0]    fill, fill_next;
  logic [wcd_pkg::CNT_W:0]      fill_inc;
  logic [wcd_pkg::ITER_W-1:0]   iter_count;

  assign head_inc = (head == wcd_pkg::PTR_W'(wcd_pkg::WINDOW_MAX - 1)) ?
                    '0 : head + 1'b1;
  assign fill_inc  = {1'b0, fill} + 1'b1;
  assign fill_next = (fill_inc > {1'b0, ws}) ? ws : fill_inc[wcd_pkg::CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      fill       <= '0;
      iter_count <= '0;
    end else if (cmd.accept) begin
      if (item.cmd) begin
        fill       <= '0;
        iter_count <= '0;
      end else begin
        head <= head_inc;
        fill <= fill_next;
        if (iter_count != wcd_pkg::ITER_MAX) iter_count <= iter_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !item.cmd) begin
      window_mem[head_inc] <= item.sample;
    end
  end

  // scan: read newest to oldest, one entry a cycle
  logic [wcd_pkg::PTR_W-1:0]    rd_ptr;
  logic [wcd_pkg::CNT_W-1:0]    rd_idx;
  logic [wcd_pkg::SAMPLE_W-1:0] rd_data;
  logic                         rd_vld;

  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      rd_data <= window_mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.read_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      rd_ptr <= head;
      rd_idx <= '0;
    end else if (cmd.read_en) begin
      rd_ptr <= (rd_ptr == '0) ? wcd_pkg::PTR_W'(wcd_pkg::WINDOW_MAX - 1) : rd_ptr - 1'b1;
      rd_idx <= rd_idx + 1'b1;
    end
  end

  // accumulators over neighbouring differences
  logic [wcd_pkg::SAMPLE_W-1:0] prev_sample;
  logic                         have_prev;
  logic                         prev_pos, prev_neg;
  logic [wcd_pkg::DIFF_W-1:0]   maxchange;
  logic [wcd_pkg::CNT_W-1:0]    reversals;
  logic [wcd_pkg::DIFF_W-1:0]   diff, diff_abs;
  logic                         d_pos, d_neg;

  assign diff     = {prev_sample[wcd_pkg::SAMPLE_W-1], prev_sample}
                  - {rd_data[wcd_pkg::SAMPLE_W-1], rd_data};
  assign d_neg    = diff[wcd_pkg::DIFF_W-1];
  assign d_pos    = !d_neg && (diff != '0);
  assign diff_abs = d_neg ? (~diff + 1'b1) : diff;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      have_prev <= 1'b0;
      prev_pos  <= 1'b0;
      prev_neg  <= 1'b0;
      maxchange <= '0;
      reversals <= '0;
    end else if (rd_vld) begin
      have_prev   <= 1'b1;
      prev_sample <= rd_data;
      if (have_prev) begin
        if (diff_abs > maxchange) maxchange <= diff_abs;
        // first difference has no previous sign, so this never fires on it
        if ((prev_pos && d_neg) || (prev_neg && d_pos)) reversals <= reversals + 1'b1;
        prev_pos <= d_pos;
        prev_neg <= d_neg;
      end
    end
  end

  // evaluation
  logic [wcd_pkg::DIFF_W-1:0]   tol_ext;
  logic [wcd_pkg::DIFF_W+3:0]   max10, tol_ext10;
  logic [wcd_pkg::REV_W-1:0]    rev10, fm2, n7;
  logic                         full, conv, osc, stag;
  wcd_pkg::trend_t              trend;

  assign tol_ext   = {{(wcd_pkg::DIFF_W - wcd_pkg::TOL_W){1'b0}}, tolerance};
  assign tol_ext10 = {4'b0, tol_ext};
  assign max10     = {1'b0, maxchange, 3'b0} + {3'b0, maxchange, 1'b0};
  assign rev10     = {1'b0, reversals, 3'b0} + {3'b0, reversals, 1'b0};
  assign fm2       = {4'b0, fill} - wcd_pkg::REV_W'(2);
  assign n7        = {fm2[wcd_pkg::REV_W-4:0], 3'b0} - fm2;

  assign full = (fill >= ws);
  assign conv = (fill >= wcd_pkg::CNT_W'(2)) && full && (maxchange < tol_ext);
  assign osc  = (fill >= wcd_pkg::CNT_W'(4)) && (rev10 >= n7);
  assign stag = full && (max10 < tol_ext10);

  always_comb begin
    if (fill == '0) begin
      trend = wcd_pkg::TREND_EMPTY;
    end else if (osc) begin
      trend = wcd_pkg::TREND_OSCILLATING;
    end else if (stag) begin
      trend = wcd_pkg::TREND_STAGNATING;
    end else begin
      trend = wcd_pkg::TREND_CONVERGING;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.eval_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_load) begin
      result.converged       <= conv;
      result.limit_reached   <= (iter_count >= max_iterations);
      result.trend           <= trend;
      result.iteration_count <= iter_count;
    end
  end

  assign stat.empty     = (fill == '0);
  assign stat.read_last = (rd_idx == fill - 1'b1);
  assign stat.out_busy  = result_valid && !result_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/wcd_checker.sv -----
// Port-level checker for the windowed convergence detector, bound to the top.
// Depends on wcd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wcd_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_ready,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire wcd_pkg::wcd_out_t result
);

  // a stalled result beat holds
  `ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result beat changed while stalled")

  // one item at a time: busy straight after an accept
  `ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready, "item accepted while previous still in work")

  // a zero count only follows reset or clear, so the window is empty
  `ASSERT_IMPL(a_zero_count_empty, result_valid && (result.iteration_count == '0), !result.converged && (result.trend == wcd_pkg::TREND_EMPTY), "zero count with non-empty trend")

  // convergence needs at least two values
  `ASSERT_IMPL(a_conv_not_empty, result_valid && result.converged, result.trend != wcd_pkg::TREND_EMPTY, "converged on empty window")

endmodule

bind windowed_convergence_detector wcd_checker u_wcd_checker (.*);

`default_nettype wire
